FILE: src/body_motion_step_defines.svh
// Assertion macros used by the port-level checker file.
`ifndef BODY_MOTION_STEP_DEFINES_SVH
`define BODY_MOTION_STEP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define BMS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define BMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/bms_pkg.sv
// Shared types, register codes and arithmetic helpers of the body motion step block.
package bms_pkg;

	localparam int NUM_STAGES = 11;
	localparam int REM_BITS_PER_STAGE = 4;
	localparam logic [24:0] Q24_ONE = 25'h100_0000;

	typedef enum logic [2:0] {
		REG_BOX_HALF_WIDTH  = 3'd0,
		REG_BOX_HALF_HEIGHT = 3'd1,
		REG_FRICTION_RATE   = 3'd2,
		REG_ANGLE_SNAP_STEP = 3'd3,
		REG_STOP_SPEED_SQ   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [30:0] box_half_width;
		logic [30:0] box_half_height;
		logic [15:0] friction_rate;
		logic [30:0] angle_snap_step;
		logic [62:0] stop_speed_squared;
	} cfg_t;

	typedef struct packed {
		logic [15:0]        tag;
		logic               dly;
		logic signed [31:0] dl;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] ang;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] sp;
		logic [30:0]        ex;
		logic [30:0]        ey;
		logic [15:0]        dt;
		logic signed [47:0] prod_x;
		logic signed [47:0] prod_y;
		logic signed [47:0] prod_a;
		logic [31:0]        fd;
		logic [24:0]        factor;
		logic signed [57:0] dprod_x;
		logic signed [57:0] dprod_y;
		logic signed [57:0] dprod_s;
		logic [62:0]        sq_x;
		logic [62:0]        sq_y;
		logic               rest;
		logic [1:0]         hx;
		logic [1:0]         hy;
		logic [30:0]        rem;
		logic [31:0]        dvd;
	} item_t;

	localparam logic [1:0] HIT_NONE = 2'd0;
	localparam logic [1:0] HIT_LOW  = 2'd1;
	localparam logic [1:0] HIT_HIGH = 2'd2;

	// Clamp a 34-bit signed value to the 32-bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [33:0] hi;
		logic signed [33:0] lo;
		hi = 34'sh0_7FFF_FFFF;
		lo = -34'sh0_8000_0000;
		if (v > hi) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	// Four restoring steps of the remainder of dvd by step, high bits first.
	function automatic logic [62:0] rem_step(input logic [30:0] rem, input logic [31:0] dvd,
			input logic [30:0] step);
		logic [31:0] t;
		logic [30:0] r;
		logic [31:0] d;
		r = rem;
		d = dvd;
		for (int i = 0; i < REM_BITS_PER_STAGE; i++) begin
			t = {r, d[31]};
			d = {d[30:0], 1'b0};
			if (t >= {1'b0, step}) begin
				r = 31'(t - {1'b0, step});
			end else begin
				r = t[30:0];
			end
		end
		rem_step = {r, d};
	endfunction

endpackage

FILE: src/bms_cfg_regs.sv
// Configuration register file of the body motion step block.
module bms_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  logic [2:0]     wr_index,
	input  logic [63:0]    wr_data,
	output bms_pkg::cfg_t  cfg
);

	bms_pkg::cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_half_width     <= 31'd20971520;
			cfg_q.box_half_height    <= 31'd15728640;
			cfg_q.friction_rate      <= 16'd256;
			cfg_q.angle_snap_step    <= 31'd5898240;
			cfg_q.stop_speed_squared <= 63'h1_0000_0000;
		end else if (wr_valid) begin
			case (bms_pkg::cfg_reg_t'(wr_index))
				bms_pkg::REG_BOX_HALF_WIDTH:  cfg_q.box_half_width <= wr_data[30:0];
				bms_pkg::REG_BOX_HALF_HEIGHT: cfg_q.box_half_height <= wr_data[30:0];
				bms_pkg::REG_FRICTION_RATE:   cfg_q.friction_rate <= wr_data[15:0];
				bms_pkg::REG_ANGLE_SNAP_STEP: cfg_q.angle_snap_step <= wr_data[30:0];
				bms_pkg::REG_STOP_SPEED_SQ:   cfg_q.stop_speed_squared <= wr_data[62:0];
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

endmodule

FILE: src/bms_pipe_reg.sv
// One pipeline stage register with valid and a local ready.
module bms_pipe_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bms_pkg::item_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output bms_pkg::item_t  out_data
);

	logic           valid_q;
	bms_pkg::item_t data_q;

	// Take a new item when empty or when the held one moves on.
	assign in_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= in_data;
		end
	end

endmodule

FILE: src/body_motion_step.sv
// Body motion step: eleven-stage pipeline from body state to updated body state.
// Throughput: one body per cycle while m_tready is high; each stage holds on its own ready, so bubbles close up.
// The snap remainder runs 4 bits per stage over stages 3 to 10.
// Reset clears all stage valid bits and loads the register defaults.
module body_motion_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// body_tag, pos_x_in, pos_y_in, angle_in, vel_x_in, vel_y_in, spin_in,
	// extent_x, extent_y, delay_in, time_step, zero fill
	input  logic [319:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// body_tag_out, pos_x_out, pos_y_out, angle_out, vel_x_out, vel_y_out, spin_out,
	// delay_out, hit_side_x, hit_side_y, came_to_rest, zero fill
	output logic [247:0]  m_tdata,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [63:0]   cfg_data
);

	localparam int NS = bms_pkg::NUM_STAGES;

	bms_pkg::cfg_t  cfg;
	bms_pkg::item_t nx [1:NS];
	bms_pkg::item_t q  [1:NS];
	logic           v_in [1:NS];
	logic           v_q  [1:NS];
	logic           rdy  [1:NS+1];

	bms_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg_valid),
		.wr_ready (cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign v_in[1] = s_tvalid;
	assign s_tready = rdy[1];
	assign rdy[NS+1] = m_tready;
	assign m_tvalid = v_q[NS];

	for (genvar k = 1; k <= NS; k++) begin : g_stage
		if (k > 1) begin : g_v
			assign v_in[k] = v_q[k-1];
		end
		bms_pipe_reg u_reg (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_in[k]),
			.in_ready  (rdy[k]),
			.in_data   (nx[k]),
			.out_valid (v_q[k]),
			.out_ready (rdy[k+1]),
			.out_data  (q[k])
		);
	end

	// Stage 1: unpack, delay countdown, rate products.
	always_comb begin
		bms_pkg::item_t d;
		logic signed [33:0] dsub;
		d = '0;
		d.tag = s_tdata[15:0];
		d.px  = s_tdata[47:16];
		d.py  = s_tdata[79:48];
		d.ang = s_tdata[111:80];
		d.vx  = s_tdata[143:112];
		d.vy  = s_tdata[175:144];
		d.sp  = s_tdata[207:176];
		d.ex  = s_tdata[238:208];
		d.ey  = s_tdata[269:239];
		d.dl  = s_tdata[301:270];
		d.dt  = s_tdata[317:302];
		d.dly = d.dl > 32'sd0;
		dsub = 34'(d.dl) - $signed({18'd0, d.dt});
		if (d.dly) begin
			d.dl = bms_pkg::sat32(dsub);
		end
		d.prod_x = 48'(d.vx * $signed({1'b0, d.dt}));
		d.prod_y = 48'(d.vy * $signed({1'b0, d.dt}));
		d.prod_a = 48'(d.sp * $signed({1'b0, d.dt}));
		d.fd = cfg.friction_rate * d.dt;
		nx[1] = d;
	end

	// Stage 2: advance position and angle, friction factor.
	always_comb begin
		bms_pkg::item_t d;
		logic signed [31:0] stx;
		logic signed [31:0] sty;
		logic signed [31:0] sta;
		d = q[1];
		stx = d.prod_x[47:16];
		sty = d.prod_y[47:16];
		sta = d.prod_a[47:16];
		if (!d.dly) begin
			d.px  = bms_pkg::sat32(34'(d.px) + 34'(stx));
			d.py  = bms_pkg::sat32(34'(d.py) + 34'(sty));
			d.ang = bms_pkg::sat32(34'(d.ang) + 34'(sta));
		end
		if (d.fd >= {7'd0, bms_pkg::Q24_ONE}) begin
			d.factor = '0;
		end else begin
			d.factor = bms_pkg::Q24_ONE - d.fd[24:0];
		end
		nx[2] = d;
	end

	// Stage 3: wall clamp, damping products, first remainder step.
	always_comb begin
		bms_pkg::item_t d;
		logic signed [33:0] pxw;
		logic signed [33:0] pyw;
		logic signed [33:0] exw;
		logic signed [33:0] eyw;
		logic signed [33:0] hww;
		logic signed [33:0] hhw;
		logic [31:0] mag;
		logic [62:0] rs;
		d = q[2];
		pxw = 34'(d.px);
		pyw = 34'(d.py);
		exw = $signed({3'd0, d.ex});
		eyw = $signed({3'd0, d.ey});
		hww = $signed({3'd0, cfg.box_half_width});
		hhw = $signed({3'd0, cfg.box_half_height});
		d.hx = bms_pkg::HIT_NONE;
		d.hy = bms_pkg::HIT_NONE;
		if (!d.dly && d.ex != '0) begin
			// the left or top test wins when both walls are crossed
			if (pxw - exw < -hww) begin
				d.px = 32'(exw - hww);
				d.hx = bms_pkg::HIT_LOW;
			end else if (pxw + exw > hww) begin
				d.px = 32'(hww - exw);
				d.hx = bms_pkg::HIT_HIGH;
			end
			if (pyw - eyw < -hhw) begin
				d.py = 32'(eyw - hhw);
				d.hy = bms_pkg::HIT_LOW;
			end else if (pyw + eyw > hhw) begin
				d.py = 32'(hhw - eyw);
				d.hy = bms_pkg::HIT_HIGH;
			end
		end
		d.dprod_x = 58'(d.vx * $signed({1'b0, d.factor}));
		d.dprod_y = 58'(d.vy * $signed({1'b0, d.factor}));
		d.dprod_s = 58'(d.sp * $signed({1'b0, d.factor}));
		mag = d.ang[31] ? 32'(-d.ang) : 32'(d.ang);
		rs = bms_pkg::rem_step('0, mag, cfg.angle_snap_step);
		d.rem = rs[62:32];
		d.dvd = rs[31:0];
		nx[3] = d;
	end

	// Stage 4: finish damping with truncation toward zero, next remainder step.
	always_comb begin
		bms_pkg::item_t d;
		logic [57:0] mx;
		logic [57:0] my;
		logic [57:0] ms;
		logic [31:0] rx;
		logic [31:0] ry;
		logic [31:0] rsp;
		logic [62:0] rs;
		d = q[3];
		mx = d.dprod_x[57] ? 58'(-d.dprod_x) : 58'(d.dprod_x);
		my = d.dprod_y[57] ? 58'(-d.dprod_y) : 58'(d.dprod_y);
		ms = d.dprod_s[57] ? 58'(-d.dprod_s) : 58'(d.dprod_s);
		rx = mx[55:24];
		ry = my[55:24];
		rsp = ms[55:24];
		if (!d.dly) begin
			d.vx = d.dprod_x[57] ? $signed(-rx) : $signed(rx);
			d.vy = d.dprod_y[57] ? $signed(-ry) : $signed(ry);
			d.sp = d.dprod_s[57] ? $signed(-rsp) : $signed(rsp);
		end
		rs = bms_pkg::rem_step(d.rem, d.dvd, cfg.angle_snap_step);
		d.rem = rs[62:32];
		d.dvd = rs[31:0];
		nx[4] = d;
	end

	// Stage 5: squared speeds, next remainder step.
	always_comb begin
		bms_pkg::item_t d;
		logic signed [63:0] px2;
		logic signed [63:0] py2;
		logic [62:0] rs;
		d = q[4];
		px2 = 64'(d.vx) * 64'(d.vx);
		py2 = 64'(d.vy) * 64'(d.vy);
		d.sq_x = px2[62:0];
		d.sq_y = py2[62:0];
		rs = bms_pkg::rem_step(d.rem, d.dvd, cfg.angle_snap_step);
		d.rem = rs[62:32];
		d.dvd = rs[31:0];
		nx[5] = d;
	end

	// Stage 6: stop test, next remainder step.
	always_comb begin
		bms_pkg::item_t d;
		logic [63:0] ssum;
		logic [62:0] rs;
		d = q[5];
		ssum = {1'b0, d.sq_x} + {1'b0, d.sq_y};
		d.rest = !d.dly && (ssum < {1'b0, cfg.stop_speed_squared});
		rs = bms_pkg::rem_step(d.rem, d.dvd, cfg.angle_snap_step);
		d.rem = rs[62:32];
		d.dvd = rs[31:0];
		nx[6] = d;
	end

	// Stages 7 to 10: advance the remainder.
	for (genvar k = 7; k <= 10; k++) begin : g_rem
		always_comb begin
			bms_pkg::item_t d;
			logic [62:0] rs;
			d = q[k-1];
			rs = bms_pkg::rem_step(d.rem, d.dvd, cfg.angle_snap_step);
			d.rem = rs[62:32];
			d.dvd = rs[31:0];
			nx[k] = d;
		end
	end

	// Stage 11: snap the angle at rest and zero the motion.
	always_comb begin
		bms_pkg::item_t d;
		logic [32:0] mag;
		logic [32:0] base;
		logic [32:0] tot;
		logic        up;
		logic        neg;
		d = q[10];
		neg = d.ang[31];
		up = !d.sp[31];
		mag = neg ? 33'(-34'(d.ang)) : 33'(d.ang);
		base = mag - {2'd0, d.rem};
		tot = base;
		if (d.rem != '0 && (up != neg)) begin
			tot = base + {2'd0, cfg.angle_snap_step};
		end
		if (d.rest) begin
			if (cfg.angle_snap_step != '0) begin
				if (!neg) begin
					d.ang = (tot > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(tot[31:0]);
				end else begin
					d.ang = (tot > 33'h0_8000_0000) ? 32'sh8000_0000 : $signed(-tot[31:0]);
				end
			end
			d.vx = '0;
			d.vy = '0;
			d.sp = '0;
		end
		nx[11] = d;
	end

	assign m_tdata = {3'd0, q[NS].rest, q[NS].hy, q[NS].hx, q[NS].dl, q[NS].sp, q[NS].vy,
		q[NS].vx, q[NS].ang, q[NS].py, q[NS].px, q[NS].tag};

endmodule

FILE: src/bms_checker.sv
// Port-level checks of the body motion step block, bound to the top level.
`include "body_motion_step_defines.svh"

module bms_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [247:0]  m_tdata
);

	`BMS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`BMS_ASSERT_NEXT(a_data_hold, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")
	`BMS_ASSERT_NOW(a_hit_code, m_tvalid, m_tdata[241:240] != 2'd3 && m_tdata[243:242] != 2'd3, "bad hit code")
	`BMS_ASSERT_NOW(a_rest_still, m_tvalid && m_tdata[244], m_tdata[207:112] == '0, "motion left at rest")

endmodule

bind body_motion_step bms_checker u_bms_checker (.*);
